// File: rtl/esnp_pkg.sv
// esnp_pkg: shared types, codes and constants of the escaped node stream parser
// no dependencies; imported by every other rtl file of the block except the two interfaces
package esnp_pkg;

    // deepest nesting that may be opened; the depth counter itself is 8 bits
    localparam int unsigned MAX_DEPTH = 255;

    localparam int unsigned DEPTH_W = 8;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ACCEPTED_ID = 2'd0;
    localparam logic [1:0] REG_START_MARKER = 2'd1;
    localparam logic [1:0] REG_END_MARKER = 2'd2;
    localparam logic [1:0] REG_ESCAPE_MARKER = 2'd3;

    localparam logic [31:0] ACCEPTED_ID_RST = 32'h0000_0000;
    localparam logic [7:0] START_MARKER_RST = 8'd254;
    localparam logic [7:0] END_MARKER_RST = 8'd255;
    localparam logic [7:0] ESCAPE_MARKER_RST = 8'd253;

    // value of the wildcard identifier
    localparam logic [31:0] ID_WILDCARD = 32'h0000_0000;

    // bytes a file needs at least, and where the byte counter stops
    localparam logic [3:0] SEEN_MIN = 4'd8;

    typedef enum logic [5:0] {
        PH_HDR        = 6'b000001,
        PH_ROOT_MARK  = 6'b000010,
        PH_ROOT_TYPE  = 6'b000100,
        PH_BODY       = 6'b001000,
        PH_CHILD_TYPE = 6'b010000,
        PH_ESCAPED    = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_PROP   = 3'd2,
        KIND_CLOSE  = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_ID        = 3'd2,
        ERR_NO_ROOT   = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_NO_NODE   = 3'd5,
        ERR_OVERFLOW  = 3'd6,
        ERR_UNCLOSED  = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] accepted_id;
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [7:0]  escape_marker;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         value;
        logic [DEPTH_W-1:0] depth;
        t_err               err;
        t_status            status;
    } t_result;

endpackage

// File: rtl/esnp_in_if.sv
// esnp_in_if: input byte channel, valid/ready with one file byte per beat
// no dependencies
interface esnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: rtl/esnp_out_if.sv
// esnp_out_if: result channel, valid/ready with one parse event per beat
// no dependencies
interface esnp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] event_value;
    logic [7:0] nest_depth;
    logic [2:0] fault_code;
    logic [1:0] stream_status;

    modport source (output valid, output event_kind, output event_value,
                    output nest_depth, output fault_code, output stream_status,
                    input ready);
    modport sink (input valid, input event_kind, input event_value,
                  input nest_depth, input fault_code, input stream_status,
                  output ready);
endinterface

// File: rtl/esnp_regs.sv
// esnp_regs: apb register file holding identifier and marker values
// depends on esnp_pkg
module esnp_regs
    import esnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accepted_id   <= ACCEPTED_ID_RST;
            r_cfg.start_marker  <= START_MARKER_RST;
            r_cfg.end_marker    <= END_MARKER_RST;
            r_cfg.escape_marker <= ESCAPE_MARKER_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ACCEPTED_ID:   r_cfg.accepted_id   <= pwdata;
                REG_START_MARKER:  r_cfg.start_marker  <= pwdata[7:0];
                REG_END_MARKER:    r_cfg.end_marker    <= pwdata[7:0];
                REG_ESCAPE_MARKER: r_cfg.escape_marker <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACCEPTED_ID:   prdata = r_cfg.accepted_id;
            REG_START_MARKER:  prdata = {24'd0, r_cfg.start_marker};
            REG_END_MARKER:    prdata = {24'd0, r_cfg.end_marker};
            REG_ESCAPE_MARKER: prdata = {24'd0, r_cfg.escape_marker};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: rtl/esnp_core.sv
// esnp_core: parse state registers and the combinational per-byte state update
// depends on esnp_pkg
module esnp_core
    import esnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output t_result    o_res
);

    t_phase             r_phase, n_phase;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_has_child, n_has_child;
    logic [3:0]         r_seen, n_seen;
    logic               r_failed, n_failed;
    logic [31:0]        r_id, n_id;

    logic [31:0]        id_acc;
    logic               is_prop;
    logic               at_limit;
    t_kind              kind;
    logic [7:0]         value;
    t_err               err;

    assign id_acc   = r_id | (32'(i_byte) << {r_seen[1:0], 3'b000});
    assign at_limit = (32'(r_depth) >= MAX_DEPTH) || (r_depth == {DEPTH_W{1'b1}});

    always_comb begin
        n_phase     = r_phase;
        n_depth     = r_depth;
        n_has_child = r_has_child;
        n_seen      = (r_seen < SEEN_MIN) ? r_seen + 4'd1 : SEEN_MIN;
        n_failed    = r_failed;
        n_id        = r_id;
        kind        = KIND_NONE;
        value       = 8'd0;
        err         = ERR_NONE;
        is_prop     = 1'b0;
        o_res       = '{KIND_NONE, 8'd0, r_depth, ERR_NONE, ST_BUSY};

        if (r_failed) begin
            // draining a rejected file until its final byte
            o_res = '{KIND_NONE, 8'd0, r_depth, ERR_NONE, ST_REJECTED};
        end else if (i_final && (r_seen < SEEN_MIN - 4'd1)) begin
            o_res = '{KIND_ERROR, 8'd0, r_depth, ERR_SHORT, ST_REJECTED};
        end else begin
            case (r_phase)
                PH_HDR: begin
                    n_id = id_acc;
                    if (r_seen[1:0] == 2'd3) begin
                        if (id_acc != i_cfg.accepted_id && id_acc != ID_WILDCARD)
                            err = ERR_ID;
                        else
                            n_phase = PH_ROOT_MARK;
                    end
                end
                PH_ROOT_MARK: begin
                    if (i_byte != i_cfg.start_marker) err = ERR_NO_ROOT;
                    else n_phase = PH_ROOT_TYPE;
                end
                PH_ROOT_TYPE: begin
                    n_depth     = DEPTH_W'(1);
                    n_has_child = 1'b0;
                    kind        = KIND_OPEN;
                    value       = i_byte;
                    n_phase     = PH_BODY;
                end
                PH_CHILD_TYPE: begin
                    n_phase = PH_BODY;
                    if (at_limit) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        n_depth     = r_depth + DEPTH_W'(1);
                        n_has_child = 1'b0;
                        kind        = KIND_OPEN;
                        value       = i_byte;
                    end
                end
                PH_ESCAPED: begin
                    n_phase = PH_BODY;
                    is_prop = 1'b1;
                end
                default: begin
                    // body: start wins over end, end over escape
                    if (i_byte == i_cfg.start_marker) begin
                        if (r_depth == '0) err = ERR_NO_NODE;
                        else if (i_final) err = ERR_TRUNCATED;
                        else n_phase = PH_CHILD_TYPE;
                    end else if (i_byte == i_cfg.end_marker) begin
                        if (r_depth == '0) begin
                            err = ERR_NO_NODE;
                        end else begin
                            n_depth     = r_depth - DEPTH_W'(1);
                            n_has_child = 1'b1;
                            kind        = KIND_CLOSE;
                        end
                    end else if (i_byte == i_cfg.escape_marker) begin
                        if (i_final) err = ERR_TRUNCATED;
                        else n_phase = PH_ESCAPED;
                    end else begin
                        is_prop = 1'b1;
                    end
                end
            endcase

            // properties only until the node gets its first child
            if (is_prop && n_depth != '0 && !n_has_child) begin
                kind  = KIND_PROP;
                value = i_byte;
            end

            if (err != ERR_NONE) begin
                o_res    = '{KIND_ERROR, 8'd0, n_depth, err, ST_REJECTED};
                n_failed = 1'b1;
            end else if (i_final) begin
                if (n_depth != '0)
                    o_res = '{KIND_ERROR, 8'd0, n_depth, ERR_UNCLOSED, ST_REJECTED};
                else
                    o_res = '{kind, value, n_depth, ERR_NONE, ST_ACCEPTED};
            end else begin
                o_res = '{kind, value, n_depth, ERR_NONE, ST_BUSY};
            end
        end

        // final byte rearms for the next file
        if (i_final) begin
            n_phase     = PH_HDR;
            n_depth     = '0;
            n_has_child = 1'b0;
            n_seen      = 4'd0;
            n_failed    = 1'b0;
            n_id        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_depth     <= '0;
            r_has_child <= 1'b0;
            r_seen      <= 4'd0;
            r_failed    <= 1'b0;
            r_id        <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_depth     <= n_depth;
            r_has_child <= n_has_child;
            r_seen      <= n_seen;
            r_failed    <= n_failed;
            r_id        <= n_id;
        end
    end

endmodule

// File: rtl/escaped_node_stream_parser.sv
// escaped_node_stream_parser: top level, input stage, output stage and assertions
// depends on esnp_pkg, esnp_in_if, esnp_out_if, esnp_regs, esnp_core
//
// Streaming parser for a byte-stuffed nested node file. One file byte enters per
// input beat, the last byte flagged by final_byte, and every byte yields exactly
// one result beat: node opened (with its type), property byte, node closed, error,
// or nothing. A file is a 4-byte identifier (equal to the accepted_id register or
// all zero), a root start marker, the raw root type byte, then a body in which a
// start marker opens a child whose raw type follows, an end marker closes a node
// and an escape marker makes the next byte literal. Property bytes are reported
// only until the current node gets its first child. After an error the rest of
// the file is swallowed with status "rejected"; the final byte always rearms the
// parser. Throughput is one byte per clock with no gaps while the result side
// takes results; back-pressure there stalls the input. Each byte is registered
// in an input stage, the whole state update is combinational in the core, and
// the result lands in an output register. The input stays ready while the
// result register is full, as long as the downstream side takes a result in
// that cycle. Marker and identifier registers sit on an APB port at byte
// addresses 0, 4, 8, 12; the user is to write them only while the parser is
// idle, and the block itself does not enforce this.
module escaped_node_stream_parser
    import esnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    esnp_in_if.sink               i_in,
    esnp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       cfg;
    t_result    core_res;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // output stage
    logic       r_out_valid;
    t_result    r_out;

    logic       in_fire;
    logic       step;

    // the byte in the input stage moves on when the result slot is free or drains
    assign step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign in_fire   = i_in.valid && i_in.ready;

    esnp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    esnp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .o_res   (core_res)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;

            if (step) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_in.data_byte;
            r_in_final <= i_in.final_byte;
        end
        if (step) r_out <= core_res;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_kind    = r_out.kind;
    assign o_out.event_value   = r_out.value;
    assign o_out.nest_depth    = r_out.depth;
    assign o_out.fault_code    = r_out.err;
    assign o_out.stream_status = r_out.status;

    // an error code shows up exactly on error events
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.err == ERR_NONE) == (r_out.kind != KIND_ERROR)))
        else $error("error code and event kind disagree");

    // an accepted file always ends with every node closed
    a_accept_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_ACCEPTED) |-> (r_out.depth == '0))
        else $error("file accepted with open nodes");

    // nesting never exceeds the MAX_DEPTH limit
    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out.depth) <= MAX_DEPTH))
        else $error("nest depth above limit");

    // a held byte in the input stage is never overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_final)))
        else $error("input stage lost a byte");

endmodule

// File: test/esnp_parse_checker.sv
// esnp_parse_checker: watches the byte and result channels and the register port,
// predicts one parse event per input beat and compares it field by field
// depends on esnp_pkg, esnp_in_if, esnp_out_if
module esnp_parse_checker
    import esnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    esnp_in_if                    i_in,
    esnp_out_if                   i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // register shadow
    logic [31:0] cfg_id;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    logic [7:0]  cfg_esc;

    // parser state
    t_phase      parse_state;
    logic [7:0]  open_nodes;
    logic        child_seen;
    logic [3:0]  byte_count;
    logic        swallowing;
    logic [31:0] id_bytes;

    t_result     due_events[$];
    int          mismatches = 0;

    function automatic void rearm_parser();
        parse_state = PH_HDR;
        open_nodes  = '0;
        child_seen  = 1'b0;
        byte_count  = '0;
        swallowing  = 1'b0;
        id_bytes    = '0;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic fin);
        logic [3:0] pos;
        t_kind      kind;
        logic [7:0] val;
        t_err       err;
        logic       literal;
        t_result    r;
        pos        = byte_count;
        kind       = KIND_NONE;
        val        = '0;
        err        = ERR_NONE;
        literal    = 1'b0;
        byte_count = (byte_count < SEEN_MIN) ? byte_count + 4'd1 : SEEN_MIN;
        r.kind     = KIND_NONE;
        r.value    = '0;
        r.depth    = open_nodes;
        r.err      = ERR_NONE;
        r.status   = ST_REJECTED;

        // rest of a rejected file is swallowed
        if (swallowing) begin
            if (fin) rearm_parser();
            return r;
        end
        // too short wins over everything else on that byte
        if (fin && byte_count < SEEN_MIN) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_SHORT;
            rearm_parser();
            return r;
        end

        case (parse_state)
            PH_HDR: begin
                id_bytes = id_bytes | (32'(b) << (8 * pos[1:0]));
                if (pos[1:0] == 2'd3) begin
                    if (id_bytes != cfg_id && id_bytes != ID_WILDCARD) err = ERR_ID;
                    else parse_state = PH_ROOT_MARK;
                end
            end
            PH_ROOT_MARK: begin
                if (b != cfg_start) err = ERR_NO_ROOT;
                else parse_state = PH_ROOT_TYPE;
            end
            PH_ROOT_TYPE: begin
                open_nodes  = 8'd1;
                child_seen  = 1'b0;
                kind        = KIND_OPEN;
                val         = b;
                parse_state = PH_BODY;
            end
            PH_CHILD_TYPE: begin
                parse_state = PH_BODY;
                if (open_nodes >= MAX_DEPTH || open_nodes == 8'd255) begin
                    err = ERR_OVERFLOW;
                end else begin
                    open_nodes = open_nodes + 8'd1;
                    child_seen = 1'b0;
                    kind       = KIND_OPEN;
                    val        = b;
                end
            end
            PH_ESCAPED: begin
                parse_state = PH_BODY;
                literal     = 1'b1;
            end
            default: begin
                // start, then end, then escape when markers share a value
                if (b == cfg_start) begin
                    if (open_nodes == 0) err = ERR_NO_NODE;
                    else if (fin) err = ERR_TRUNCATED;
                    else parse_state = PH_CHILD_TYPE;
                end else if (b == cfg_end) begin
                    if (open_nodes == 0) begin
                        err = ERR_NO_NODE;
                    end else begin
                        open_nodes = open_nodes - 8'd1;
                        child_seen = 1'b1;
                        kind       = KIND_CLOSE;
                    end
                end else if (b == cfg_esc) begin
                    if (fin) err = ERR_TRUNCATED;
                    else parse_state = PH_ESCAPED;
                end else begin
                    literal = 1'b1;
                end
            end
        endcase

        if (literal && open_nodes != 0 && !child_seen) begin
            kind = KIND_PROP;
            val  = b;
        end

        r.depth = open_nodes;
        if (err != ERR_NONE) begin
            r.kind = KIND_ERROR;
            r.err  = err;
            if (fin) rearm_parser();
            else swallowing = 1'b1;
            return r;
        end
        if (fin) begin
            if (open_nodes != 0) begin
                r.kind = KIND_ERROR;
                r.err  = ERR_UNCLOSED;
            end else begin
                r.kind   = kind;
                r.value  = val;
                r.status = ST_ACCEPTED;
            end
            rearm_parser();
            return r;
        end
        r.kind   = kind;
        r.value  = val;
        r.status = ST_BUSY;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rearm_parser();
            cfg_id    = ACCEPTED_ID_RST;
            cfg_start = START_MARKER_RST;
            cfg_end   = END_MARKER_RST;
            cfg_esc   = ESCAPE_MARKER_RST;
            due_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ACCEPTED_ID:   cfg_id    = i_pwdata;
                    REG_START_MARKER:  cfg_start = i_pwdata[7:0];
                    REG_END_MARKER:    cfg_end   = i_pwdata[7:0];
                    REG_ESCAPE_MARKER: cfg_esc   = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                due_events.push_back(parse_byte(i_in.data_byte, i_in.final_byte));
            if (i_out.valid && i_out.ready) begin
                if (due_events.size() == 0) begin
                    $error("result beat with no event due");
                    mismatches++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_kind", want.kind, i_out.event_kind);
                    check_field("event_value", want.value, i_out.event_value);
                    check_field("nest_depth", want.depth, i_out.nest_depth);
                    check_field("fault_code", want.err, i_out.fault_code);
                    check_field("stream_status", want.status, i_out.stream_status);
                end
            end
        end
        o_pending    = due_events.size();
        o_fail_count = mismatches;
    end

endmodule

// File: test/tb.sv
// tb: top of the parser testbench; clock, reset, file stimulus, result sink and watchdog
// depends on esnp_pkg, esnp_in_if, esnp_out_if, esnp_parse_checker and the parser rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import esnp_pkg::*;

    // cycles with no beat and no register access before the run is declared hung
    localparam int QUIET_LIMIT = 3000;
    // input beat count at which the result side starts its long hold-off
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    esnp_in_if  in_ch();
    esnp_out_if out_ch();

    int fail_count;
    int pending;
    int in_beats = 0;
    int quiet_cycles = 0;

    // register values as last written, used to shape the files
    logic [31:0] cur_id    = ACCEPTED_ID_RST;
    logic [7:0]  cur_start = START_MARKER_RST;
    logic [7:0]  cur_end   = END_MARKER_RST;
    logic [7:0]  cur_esc   = ESCAPE_MARKER_RST;

    // file being sent, final flag goes on its last byte
    logic [7:0]  file_bytes[$];
    // no gaps at all while sending the current file
    bit          steady_feed;

    escaped_node_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    esnp_parse_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // raw bytes lean toward marker values, which is where the parser branches
    function automatic logic [7:0] pick_raw_byte();
        case ($urandom_range(7))
            0: return cur_start;
            1: return cur_end;
            2: return cur_esc;
            default: return 8'($urandom);
        endcase
    endfunction

    // ordinary property byte, never one of the markers
    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == cur_start || b == cur_end || b == cur_esc);
        return b;
    endfunction

    // one byte beat; valid stays up across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.data_byte  = b;
        in_ch.final_byte = fin;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_file();
        steady_feed = ($urandom_range(4) == 0);
        foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1);
    endtask

    // stop offering bytes and let every due result come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [31:0] id, input logic [7:0] s, e, x);
        write_reg(REG_ACCEPTED_ID, id);
        write_reg(REG_START_MARKER, {24'd0, s});
        write_reg(REG_END_MARKER, {24'd0, e});
        write_reg(REG_ESCAPE_MARKER, {24'd0, x});
        cur_id    = id;
        cur_start = s;
        cur_end   = e;
        cur_esc   = x;
    endtask

    // mostly well-formed nested files with random content; the rest are
    // short, noisy or broken in one specific way
    task automatic make_random_file();
        int          pick;
        int          depth;
        int          max_depth;
        int          cut;
        logic [31:0] id;
        pick = $urandom_range(99);
        file_bytes.delete();
        if (pick < 8) begin
            repeat ($urandom_range(1, 7)) file_bytes.push_back(pick_raw_byte());
            return;
        end
        if (pick < 14) begin
            repeat ($urandom_range(8, 40)) file_bytes.push_back(8'($urandom));
            return;
        end

        // header: accepted or wildcard id, or a wrong one
        id = $urandom_range(1) ? cur_id : ID_WILDCARD;
        if (pick >= 60 && pick < 66) begin
            id = $urandom;
            if (id == cur_id || id == ID_WILDCARD) id = ~cur_id | 32'd1;
        end
        for (int k = 0; k < 4; k++) file_bytes.push_back(id[8*k +: 8]);

        // root marker, or something else in its place
        if (pick >= 66 && pick < 72)
            file_bytes.push_back(cur_start + 8'($urandom_range(1, 255)));
        else
            file_bytes.push_back(cur_start);
        file_bytes.push_back(pick_raw_byte());

        // body: children, closes, escaped pairs and plain properties
        depth     = 1;
        max_depth = $urandom_range(1, 6);
        repeat ($urandom_range(0, 24)) begin
            case ($urandom_range(3))
                0: begin
                    if (depth < max_depth) begin
                        file_bytes.push_back(cur_start);
                        file_bytes.push_back(pick_raw_byte());
                        depth++;
                    end
                end
                1: begin
                    if (depth > 1) begin
                        file_bytes.push_back(cur_end);
                        depth--;
                    end
                end
                2: begin
                    file_bytes.push_back(cur_esc);
                    file_bytes.push_back(pick_raw_byte());
                end
                default: file_bytes.push_back(pick_plain_byte());
            endcase
        end
        while (file_bytes.size() + depth < 8) file_bytes.push_back(pick_plain_byte());
        repeat (depth) file_bytes.push_back(cur_end);

        // bytes after the root has closed
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(1)) begin
                file_bytes.push_back(pick_plain_byte());
            end else begin
                file_bytes.push_back(cur_esc);
                file_bytes.push_back(pick_raw_byte());
            end
        end

        if (pick >= 72 && pick < 80) begin
            // ends on a start or escape marker
            cut = $urandom_range(6, file_bytes.size() - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            file_bytes.push_back($urandom_range(1) ? cur_start : cur_esc);
        end else if (pick >= 80 && pick < 87) begin
            // cut off while nodes may still be open
            cut = $urandom_range(7, file_bytes.size() - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end else if (pick >= 87 && pick < 94) begin
            // marker with no open node
            file_bytes.push_back($urandom_range(1) ? cur_end : cur_start);
            repeat ($urandom_range(0, 3)) file_bytes.push_back(pick_plain_byte());
        end else if (pick >= 94) begin
            repeat ($urandom_range(1, 3))
                file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
        end
    endtask

    task automatic run_random_files(input int beat_target);
        while (in_beats < beat_target) begin
            make_random_file();
            send_file();
        end
    endtask

    // beat counter and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_beats     <= 0;
            quiet_cycles <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) in_beats <= in_beats + 1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random ready with busy runs and stalls, plus one long
    // hold-off so the parser backs up and stalls its input
    initial begin
        bit held_long;
        int stall;
        held_long    = 1'b0;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!held_long && in_beats >= HOLD_AT) begin
                held_long    = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
                repeat (($urandom_range(9) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(1, 8))
                    @(negedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    out_ch.ready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
        end
    end

    // stimulus: phases of register settings, each one ends with a full drain
    initial begin
        logic [7:0] s;
        logic [7:0] e;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        steady_feed      = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values; directed files first
        // final byte as the third byte: too short
        file_bytes = {8'h00, 8'hFF, 8'h80};
        send_file();
        // wrong identifier, the rest of the file is swallowed
        file_bytes = {8'h01, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'hFF, 8'h7F};
        send_file();
        // wildcard id, root, escaped marker as property, one child, property
        // hidden after the child, root closed on the final byte
        file_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'hFD, 8'hFE,
                      8'h41, 8'hFE, 8'h07, 8'h42, 8'hFF, 8'h43, 8'hFF};
        send_file();
        run_random_files(250);
        wait_drained();

        // extreme id and marker values
        configure(32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h80);
        // root plus children up to the depth limit, then one more open
        file_bytes.delete();
        for (int k = 0; k < 4; k++) file_bytes.push_back(cur_id[8*k +: 8]);
        file_bytes.push_back(cur_start);
        file_bytes.push_back(pick_raw_byte());
        repeat (MAX_DEPTH - 1) begin
            if ($urandom_range(3) == 0) file_bytes.push_back(pick_plain_byte());
            file_bytes.push_back(cur_start);
            file_bytes.push_back(pick_raw_byte());
        end
        file_bytes.push_back(cur_start);
        file_bytes.push_back(pick_raw_byte());
        file_bytes.push_back(pick_plain_byte());
        file_bytes.push_back(pick_plain_byte());
        send_file();
        run_random_files(800);
        wait_drained();

        // all three markers share a value: start always wins
        configure($urandom, 8'h41, 8'h41, 8'h41);
        run_random_files(920);
        wait_drained();

        // end and escape share a value: end wins
        configure($urandom, 8'h30, 8'h31, 8'h31);
        run_random_files(1040);
        wait_drained();

        configure(32'h0000_0000, 8'hFF, 8'h00, 8'h01);
        run_random_files(1200);
        wait_drained();

        // random distinct markers
        s = 8'($urandom);
        e = s + 8'($urandom_range(1, 127));
        configure($urandom, s, e, e + 8'($urandom_range(1, 127)));
        run_random_files(1400);
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

endmodule
